### rtl/mrr_pkg.sv
// Shared types and constants of the matrix rotate/reflect block.
package mrr_pkg;

  // Action codes of an input word; code 3 means nothing and is dropped.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_XFORM = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Transform request codes; codes 5 to 7 mean nothing and are dropped.
  typedef enum logic [2:0] {
    OP_FLIP_TB = 3'd0,
    OP_FLIP_LR = 3'd1,
    OP_ROT_90  = 3'd2,
    OP_ROT_180 = 3'd3,
    OP_ROT_270 = 3'd4
  } op_e;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  // Dimension value after reset, before clamping to the maximum.
  localparam int unsigned DIM_RESET = 64;

  // Folded transform: transpose, then row flip and column flip.
  typedef struct packed {
    logic t;
    logic fr;
    logic fc;
  } xform_t;

endpackage

### rtl/mrr_if.sv
// Valid/ready channel interfaces of the matrix rotate/reflect block.
interface mrr_in_if
  import mrr_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic        [ACTION_W-1:0]   action;
  logic signed [DATA_WIDTH-1:0] element;
  logic        [OP_W-1:0]       op;

  modport source (output valid, action, element, op, input ready);
  modport sink   (input valid, action, element, op, output ready);
endinterface

interface mrr_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         row_end;
  logic                         last;

  modport source (output valid, value, row_end, last, input ready);
  modport sink   (input valid, value, row_end, last, output ready);
endinterface

### rtl/matrix_rotate_reflect_top.sv
// Matrix rotate/reflect unit: element store, folded transform and read sequencer.
// An accepted read word passes the memory read register, then the output register.
// Throughput: one word per cycle of any kind unless the input stalls; one write
//   port serves loads, one registered read port reads; neither waits on the other.
// Reset: transform, counters and dimensions (64, clamped to MAX_DIM) clear at once;
//   the element store is not cleared, and there is no clearing pass after reset.
module matrix_rotate_reflect_top
  import mrr_pkg::*;
#(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mrr_in_if.sink                in_if,
  mrr_out_if.source             out_if
);

  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PROD_W  = IDX_W + DIM_W;
  localparam int unsigned DIM_RST = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;

  // Element store: one write port for loads, one registered read port.
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  // Control state.
  logic [DIM_W-1:0] rows_q, rows_d;
  logic [DIM_W-1:0] cols_q, cols_d;
  xform_t           xform_q, xform_d;
  logic [CNT_W-1:0] load_pos_q, load_pos_d;
  logic [IDX_W-1:0] read_row_q, read_row_d;
  logic [IDX_W-1:0] read_col_q, read_col_d;

  // Read pipeline: stage 1 waits for the memory, then the output register.
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_row_end_q;
  logic                  s1_last_q;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] value_q;
  logic                  row_end_q;
  logic                  last_q;

  logic in_acc;
  logic s1_move;
  logic load_acc;
  logic xform_acc;
  logic read_acc;

  logic [DIM_W-1:0]  dim_new;
  logic [CNT_W-1:0]  cells;
  logic              load_ok;
  logic [DIM_W-1:0]  out_rows;
  logic [DIM_W-1:0]  out_cols;
  logic              wrap;
  logic [IDX_W-1:0]  row_cur;
  logic [IDX_W-1:0]  col_cur;
  logic [IDX_W-1:0]  u_idx;
  logic [IDX_W-1:0]  v_idx;
  logic [DIM_W-1:0]  i_full;
  logic [DIM_W-1:0]  j_full;
  logic [PROD_W-1:0] rd_prod;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_row_end;
  logic              rd_last;

  // Stall the input only when both the memory stage and the output are full
  // and the output word is not being taken.
  assign s1_move      = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !(s1_valid_q && !s1_move);
  assign in_acc       = in_if.valid && in_if.ready;
  assign load_acc     = in_acc && (in_if.action == ACT_LOAD);
  assign xform_acc    = in_acc && (in_if.action == ACT_XFORM);
  assign read_acc     = in_acc && (in_if.action == ACT_READ);

  assign out_if.valid   = out_valid_q;
  assign out_if.value   = value_q;
  assign out_if.row_end = row_end_q;
  assign out_if.last    = last_q;

  // Clamp a written dimension into 1..MAX_DIM.
  always_comb begin
    if (cfg_data_i == '0) begin
      dim_new = DIM_W'(1);
    end else if (int'(cfg_data_i) > int'(MAX_DIM)) begin
      dim_new = DIM_W'(MAX_DIM);
    end else begin
      dim_new = DIM_W'(cfg_data_i);
    end
  end

  // Loads stop once the matrix is full.
  assign cells   = CNT_W'(rows_q) * CNT_W'(cols_q);
  assign load_ok = load_pos_q < cells;

  // Map the output position back to a source address. Output dimensions swap
  // under transpose; a position left outside them by a transform restarts at
  // the origin.
  always_comb begin
    out_rows = xform_q.t ? cols_q : rows_q;
    out_cols = xform_q.t ? rows_q : cols_q;
    wrap     = (DIM_W'(read_row_q) >= out_rows) || (DIM_W'(read_col_q) >= out_cols);
    row_cur  = wrap ? '0 : read_row_q;
    col_cur  = wrap ? '0 : read_col_q;
    u_idx    = xform_q.t ? col_cur : row_cur;
    v_idx    = xform_q.t ? row_cur : col_cur;
    i_full   = xform_q.fr ? (rows_q - DIM_W'(1) - DIM_W'(u_idx)) : DIM_W'(u_idx);
    j_full   = xform_q.fc ? (cols_q - DIM_W'(1) - DIM_W'(v_idx)) : DIM_W'(v_idx);
    rd_prod  = PROD_W'(i_full[IDX_W-1:0]) * PROD_W'(cols_q) + PROD_W'(j_full[IDX_W-1:0]);
    rd_addr  = rd_prod[ADDR_W-1:0];

    rd_row_end = DIM_W'(col_cur) == (out_cols - DIM_W'(1));
    rd_last    = rd_row_end && (DIM_W'(row_cur) == (out_rows - DIM_W'(1)));
  end

  // Next state of dimensions, transform and counters.
  always_comb begin
    rows_d     = rows_q;
    cols_d     = cols_q;
    xform_d    = xform_q;
    load_pos_d = load_pos_q;
    read_row_d = read_row_q;
    read_col_d = read_col_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS: rows_d = dim_new;
        REG_COLS: cols_d = dim_new;
        default: ;
      endcase
      xform_d    = '0;
      load_pos_d = '0;
      read_row_d = '0;
      read_col_d = '0;
    end else begin
      if (load_acc && load_ok) begin
        load_pos_d = load_pos_q + CNT_W'(1);
      end

      // Fold the request into (T, FR, FC); a vertical flip hits the row flag
      // unless transposed, a horizontal flip the column flag.
      if (xform_acc) begin
        case (in_if.op)
          OP_FLIP_TB: begin
            if (xform_q.t) xform_d.fc = !xform_q.fc;
            else           xform_d.fr = !xform_q.fr;
          end
          OP_FLIP_LR: begin
            if (xform_q.t) xform_d.fr = !xform_q.fr;
            else           xform_d.fc = !xform_q.fc;
          end
          OP_ROT_90: begin
            xform_d.t = !xform_q.t;
            if (!xform_q.t) xform_d.fr = !xform_q.fr;
            else            xform_d.fc = !xform_q.fc;
          end
          OP_ROT_180: begin
            xform_d.fr = !xform_q.fr;
            xform_d.fc = !xform_q.fc;
          end
          OP_ROT_270: begin
            xform_d.t = !xform_q.t;
            if (!xform_q.t) xform_d.fc = !xform_q.fc;
            else            xform_d.fr = !xform_q.fr;
          end
          default: ;
        endcase
      end

      // Advance the read position in output row-major order, wrap at the end.
      if (read_acc) begin
        if ((DIM_W'(col_cur) + DIM_W'(1)) < out_cols) begin
          read_row_d = row_cur;
          read_col_d = col_cur + IDX_W'(1);
        end else begin
          read_col_d = '0;
          if ((DIM_W'(row_cur) + DIM_W'(1)) < out_rows) begin
            read_row_d = row_cur + IDX_W'(1);
          end else begin
            read_row_d = '0;
          end
        end
      end
    end
  end

  // Pipeline valid flags.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (read_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= DIM_W'(DIM_RST);
      cols_q      <= DIM_W'(DIM_RST);
      xform_q     <= '0;
      load_pos_q  <= '0;
      read_row_q  <= '0;
      read_col_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      xform_q     <= xform_d;
      load_pos_q  <= load_pos_d;
      read_row_q  <= read_row_d;
      read_col_q  <= read_col_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Store: write a loaded word, read for an accepted read word. The read data
  // register holds while stage 1 stalls, since no read is accepted then.
  always_ff @(posedge clk_i) begin
    if (load_acc && load_ok && !cfg_we_i) begin
      mem_q[load_pos_q[ADDR_W-1:0]] <= in_if.element;
    end
    if (read_acc) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (read_acc) begin
      s1_row_end_q <= rd_row_end;
      s1_last_q    <= rd_last;
    end
    if (s1_move) begin
      value_q   <= rd_data_q;
      row_end_q <= s1_row_end_q;
      last_q    <= s1_last_q;
    end
  end

`ifndef SYNTHESIS
  // The input stalls only behind a held output word.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (out_valid_q && !out_if.ready))
    else $error("input stalled without a held output word");

  // An accepted read reaches the memory stage next cycle.
  a_read_enters_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_acc |=> s1_valid_q)
    else $error("accepted read lost before the memory stage");

  // A stalled memory stage keeps its word and its read data.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(rd_data_q)))
    else $error("memory stage dropped or changed a stalled word");

  // A configuration write clears the transform and all counters.
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (xform_q == '0 && load_pos_q == '0 && read_row_q == '0
                  && read_col_q == '0))
    else $error("configuration write did not clear progress");

  // The load counter never passes the matrix size.
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && !$past(cfg_we_i)) |-> (load_pos_q <= cells))
    else $error("load position beyond matrix size");
`endif

endmodule

### sim/tb.sv
// Testbench of matrix_rotate_reflect_top: predicts every read word and checks it field by field.
module tb;
  import mrr_pkg::*;

  localparam int unsigned MAX_DIM       = 64;
  localparam int unsigned DATA_WIDTH    = 32;
  localparam int unsigned STORE_DEPTH   = MAX_DIM * MAX_DIM;
  // Cycles with no handshake at all before the run is declared hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Margin after the last read word arrives, before a register write.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Words loaded under the reset shape; covers every address any later shape reads.
  localparam int unsigned RESET_LOADS   = 80;
  // Reads under the reset shape; stays inside the loaded part and crosses a row end.
  localparam int unsigned RESET_READS   = 75;

  // Action code that means nothing; the block drops it.
  localparam logic [ACTION_W-1:0]   ACT_NONE      = 2'd3;
  // Highest transform code the field can carry; codes above OP_ROT_270 are dropped.
  localparam logic [OP_W-1:0]       OP_CODE_MAX   = 3'd7;
  localparam logic [CFG_DATA_W-1:0] DIM_FIELD_MAX = 7'h7f;

  typedef logic        [ACTION_W-1:0]   act_bits_t;
  typedef logic        [OP_W-1:0]       op_bits_t;
  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  // One word of the output channel as the transformed matrix should produce it.
  typedef struct packed {
    elem_t value;
    logic  row_end;
    logic  last;
  } read_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mrr_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  mrr_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();

  matrix_rotate_reflect_top #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Shadow copy of the block: stored matrix, dimensions, folded transform and positions.
  elem_t       img_mem [STORE_DEPTH];
  int unsigned img_rows;
  int unsigned img_cols;
  int unsigned load_pos;
  int unsigned rd_row;
  int unsigned rd_col;
  xform_t      xf;

  // Read words accepted on the input and not yet seen on the output, oldest first.
  read_word_t  pending_reads[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned err_cnt       = 0;
  int unsigned quiet_cycles  = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic int unsigned clamp_dim(int unsigned d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic void clear_progress();
    xf       = '0;
    load_pos = 0;
    rd_row   = 0;
    rd_col   = 0;
  endfunction

  // A flip is taken in output terms, so under transpose it lands on the other axis.
  function automatic void fold_flip_tb();
    if (xf.t) xf.fc = ~xf.fc;
    else xf.fr = ~xf.fr;
  endfunction

  function automatic void fold_flip_lr();
    if (xf.t) xf.fr = ~xf.fr;
    else xf.fc = ~xf.fc;
  endfunction

  // A register write also clears the transform and both counters; the store is kept.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_ROWS) img_rows = clamp_dim(data);
    else img_cols = clamp_dim(data);
    clear_progress();
  endfunction

  // Advance the shadow state by one accepted input word; queue a read word when one is due.
  function automatic void predict_word(act_bits_t act, elem_t elem, op_bits_t opc);
    int unsigned out_rows;
    int unsigned out_cols;
    int unsigned u;
    int unsigned v;
    int unsigned i;
    int unsigned j;
    read_word_t  w;
    case (act)
      ACT_LOAD: begin
        // Drop loads once the whole matrix is in.
        if (load_pos < img_rows * img_cols) begin
          img_mem[load_pos] = elem;
          load_pos++;
        end
      end
      ACT_XFORM: begin
        case (opc)
          OP_FLIP_TB: fold_flip_tb();
          OP_FLIP_LR: fold_flip_lr();
          OP_ROT_90: begin
            xf.t = ~xf.t;
            fold_flip_lr();
          end
          OP_ROT_180: begin
            xf.fr = ~xf.fr;
            xf.fc = ~xf.fc;
          end
          OP_ROT_270: begin
            xf.t = ~xf.t;
            fold_flip_tb();
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        out_rows = xf.t ? img_cols : img_rows;
        out_cols = xf.t ? img_rows : img_cols;
        // A transpose may leave the position outside the new shape: restart at the origin.
        if (rd_row >= out_rows || rd_col >= out_cols) begin
          rd_row = 0;
          rd_col = 0;
        end
        u = xf.t ? rd_col : rd_row;
        v = xf.t ? rd_row : rd_col;
        i = xf.fr ? img_rows - 1 - u : u;
        j = xf.fc ? img_cols - 1 - v : v;
        w.value   = img_mem[i * img_cols + j];
        w.row_end = (rd_col == out_cols - 1);
        w.last    = w.row_end && (rd_row == out_rows - 1);
        pending_reads.push_back(w);
        if (rd_col + 1 < out_cols) begin
          rd_col++;
        end else begin
          rd_col = 0;
          rd_row = (rd_row + 1 < out_rows) ? rd_row + 1 : 0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one input word. Valid stays high after acceptance so back-to-back words
  // never lower and raise it in one step; an idle gap lowers it first.
  task automatic send_word(act_bits_t act, elem_t elem, op_bits_t opc);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.action  <= act_bits_t'($urandom());
      in_ch.element <= elem_t'($urandom());
      in_ch.op      <= op_bits_t'($urandom());
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.element <= elem;
    in_ch.op      <= opc;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(act, elem, opc);
  endtask

  // Drop valid, wait for every queued read word, then let the pipeline run empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both dimension registers back to back, rows first; call only when settled.
  task automatic write_dims(logic [CFG_DATA_W-1:0] rows_val, logic [CFG_DATA_W-1:0] cols_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ROWS;
    cfg_data <= rows_val;
    @(posedge clk);
    apply_reg(REG_ROWS, rows_val);
    cfg_idx  <= REG_COLS;
    cfg_data <= cols_val;
    @(posedge clk);
    apply_reg(REG_COLS, cols_val);
    cfg_we   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, compare each accepted word with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_p
    read_word_t exp_w;
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        $error("read word with no expectation: value %0d", out_ch.value);
        err_cnt++;
      end else begin
        exp_w = pending_reads.pop_front();
        if (out_ch.value !== exp_w.value) begin
          $error("value: expected %0d, got %0d", exp_w.value, out_ch.value);
          err_cnt++;
        end
        if (out_ch.row_end !== exp_w.row_end) begin
          $error("row_end: expected %0b, got %0b", exp_w.row_end, out_ch.row_end);
          err_cnt++;
        end
        if (out_ch.last !== exp_w.last) begin
          $error("last: expected %0b, got %0b", exp_w.last, out_ch.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset dimensions (64 by 64): load the first rows, enough to back every read of the
  // smaller shapes used later, then read across a row end. Transforms come in pairs
  // that cancel, so the position holds and every read stays inside the loaded part.
  task automatic test_reset_size();
    op_bits_t opc;
    op_bits_t opc_inv;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    for (int n = 0; n < RESET_LOADS; n++) begin
      send_word(ACT_LOAD, elem_t'($urandom()), op_bits_t'($urandom()));
    end
    for (int n = 0; n < RESET_READS; n++) begin
      if (n % 40 == 39) begin
        opc = op_bits_t'($urandom_range(0, OP_ROT_270));
        case (opc)
          OP_ROT_90:  opc_inv = OP_ROT_270;
          OP_ROT_270: opc_inv = OP_ROT_90;
          default:    opc_inv = opc;
        endcase
        send_word(ACT_XFORM, elem_t'($urandom()), opc);
        send_word(ACT_XFORM, elem_t'($urandom()), opc_inv);
      end
      send_word(ACT_READ, elem_t'($urandom()), op_bits_t'($urandom()));
    end
    settle();
  endtask

  // Small 2x3 matrix: field extremes, each transform code, the dropped codes, and the
  // restart when a transpose leaves the read position outside the new shape.
  task automatic test_directed();
    write_dims(7'd2, 7'd3);
    send_word(ACT_LOAD, 32'sh8000_0000, OP_FLIP_TB);
    send_word(ACT_LOAD, 32'sh7fff_ffff, OP_CODE_MAX);
    send_word(ACT_LOAD, 32'sh0000_0000, OP_FLIP_TB);
    send_word(ACT_LOAD, 32'shffff_ffff, OP_CODE_MAX);
    send_word(ACT_LOAD, 32'sh5a5a_5a5a, OP_ROT_90);
    send_word(ACT_LOAD, 32'sha5a5_a5a5, OP_ROT_270);
    send_word(ACT_LOAD, 32'sh1234_5678, OP_FLIP_TB);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    // Now at column 2; the transposed shape has two columns, so the next read restarts.
    send_word(ACT_XFORM, '0, OP_ROT_90);
    repeat (3) send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_XFORM, '0, OP_FLIP_TB);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_XFORM, '0, OP_FLIP_LR);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_XFORM, '0, OP_ROT_180);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_XFORM, '0, OP_ROT_270);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_XFORM, 32'shffff_ffff, OP_CODE_MAX);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    send_word(ACT_NONE, 32'shffff_ffff, OP_CODE_MAX);
    send_word(ACT_READ, '0, OP_FLIP_TB);
    settle();
  endtask

  // Phases of random words under each idling mode: set the shape, load a matrix, then
  // mostly reads and transforms with some surplus loads and dropped words in between.
  task automatic test_random();
    logic [CFG_DATA_W-1:0] rows_val;
    logic [CFG_DATA_W-1:0] cols_val;
    int unsigned           n_load;
    int unsigned           pick;
    op_bits_t              opc;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
        default: begin src_idle_pct = 14; snk_stall_pct = 14; end
      endcase
      case (ph)
        0: begin rows_val = 7'd3;  cols_val = 7'd5;          end
        1: begin rows_val = 7'd0;  cols_val = DIM_FIELD_MAX; end  // clamps to 1 x 64
        2: begin rows_val = 7'd64; cols_val = 7'd1;          end
        3: begin rows_val = 7'd1;  cols_val = 7'd1;          end
        4: begin rows_val = 7'd100; cols_val = 7'd0;         end  // clamps to 64 x 1
        default: begin
          rows_val = 7'($urandom_range(1, 8));
          cols_val = 7'($urandom_range(1, 8));
        end
      endcase
      write_dims(rows_val, cols_val);
      // Usually the full matrix, sometimes only part; old contents fill the rest.
      n_load = clamp_dim(rows_val) * clamp_dim(cols_val);
      if ($urandom_range(0, 3) == 0) n_load = n_load / 2;
      for (int n = 0; n < n_load; n++) begin
        send_word(ACT_LOAD, elem_t'($urandom()), op_bits_t'($urandom()));
      end
      for (int n = 0; n < 25; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_word(ACT_READ, elem_t'($urandom()), op_bits_t'($urandom()));
        end else if (pick < 70) begin
          if ($urandom_range(0, 9) == 0)
            opc = op_bits_t'($urandom_range(int'(OP_ROT_270) + 1, OP_CODE_MAX));
          else
            opc = op_bits_t'($urandom_range(0, OP_ROT_270));
          send_word(ACT_XFORM, elem_t'($urandom()), opc);
        end else if (pick < 88) begin
          send_word(ACT_LOAD, elem_t'($urandom()), op_bits_t'($urandom()));
        end else begin
          send_word(ACT_NONE, elem_t'($urandom()), op_bits_t'($urandom()));
        end
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_ROWS;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_NONE;
    in_ch.element = '0;
    in_ch.op      = OP_FLIP_TB;
    out_ch.ready  = 1'b0;
    img_rows      = clamp_dim(DIM_RESET);
    img_cols      = clamp_dim(DIM_RESET);
    clear_progress();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_directed();
    test_random();

    settle();
    if (pending_reads.size() != 0) begin
      $error("%0d read words never arrived", pending_reads.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
